// ----- sv/bpa_pkg.sv -----
// Shared constants, codes and handshake structs of the block pool allocator.
`default_nettype none

package bpa_pkg;

  // Pool geometry and field widths.
  localparam int NUM_BLOCKS = 1024;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = ADDR_W + 1;
  localparam int IDX_W      = 10;
  localparam int TAG_W      = 32;
  localparam int LEN_W      = 16;
  localparam int CNT_W      = 32;
  localparam int FREE_W     = 11;

  // A link value at or above the pool size means "no slot".
  localparam logic [LINK_W-1:0] NO_SLOT  = '1;
  localparam logic [LINK_W-1:0] NUM_LINK = LINK_W'(NUM_BLOCKS);

  // Request and status codes.
  localparam logic REQ_ALLOC    = 1'b0;
  localparam logic REQ_FREE     = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REL1,
    S_REL2,
    S_TAKE1,
    S_TAKE2,
    S_TAKE3,
    S_FIN
  } bpa_state_t;

  // Source of the link memory read address.
  typedef enum logic [0:0] {
    RD_REQ,
    RD_TOP
  } bpa_rd_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        accept;
    logic        rd_issue;
    bpa_rd_src_t rd_src;
    logic        evict_mark;
    logic        stale;
    logic        rel_link;
    logic        rel_push;
    logic        take_pop;
    logic        take_link;
    logic        finish;
  } bpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_free;
    logic in_range_bad;
    logic evict_need;
    logic req_free;
    logic hit;
    logic out_free;
  } bpa_stat_t;

endpackage

`default_nettype wire

// ----- sv/block_pool_allocator_with_eviction.sv -----
// Top level of the block pool allocator with oldest-first eviction.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   req_type, slot_index, tag, length
//   out      output     out_valid / out_ready status, granted_slot, granted_tag,
//                                             granted_length, evicted, evicted_tag,
//                                             read_from_swap, swapped_count, free_slots
//
// One request is worked at a time. After its transfer an allocate with a free slot
// steps through TAKE2, TAKE3 and FIN, an evicting one first through CHECK, REL1, REL2
// and TAKE1, a matching free through CHECK, REL1, REL2 and FIN, a stale free through
// CHECK and FIN and a bad index straight to FIN. The result register loads in FIN
// before the return to IDLE; the steps follow the dependent link memory accesses.
// The result sits in an output register, so the next request is taken while it waits;
// a stalled result only holds back the one after it. No clearing pass runs at reset.
`default_nettype none

module block_pool_allocator_with_eviction import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [IDX_W-1:0]  slot_index,
  input  logic [TAG_W-1:0]  tag,
  input  logic [LEN_W-1:0]  length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [IDX_W-1:0]  granted_slot,
  output logic [TAG_W-1:0]  granted_tag,
  output logic [LEN_W-1:0]  granted_length,
  output logic              evicted,
  output logic [TAG_W-1:0]  evicted_tag,
  output logic              read_from_swap,
  output logic [CNT_W-1:0]  swapped_count,
  output logic [FREE_W-1:0] free_slots
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .slot_index     (slot_index),
    .tag            (tag),
    .length         (length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_slot   (granted_slot),
    .granted_tag    (granted_tag),
    .granted_length (granted_length),
    .evicted        (evicted),
    .evicted_tag    (evicted_tag),
    .read_from_swap (read_from_swap),
    .swapped_count  (swapped_count),
    .free_slots     (free_slots)
  );

  // A request transfer always leaves the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transfer");

  // The free count never passes the pool size.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (free_slots <= FREE_W'(NUM_BLOCKS)))
    else $error("free slot count above pool size");

  // An eviction happens only on a full pool, which stays full after it.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> ((free_slots == '0) && !read_from_swap &&
                                (status == STATUS_OK)))
    else $error("eviction result inconsistent");

  // A bad index changes nothing and raises no flags.
  a_range_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_RANGE)) |-> (!evicted && !read_from_swap))
    else $error("range error with swap flags set");

endmodule

`default_nettype wire

// ----- sv/bpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/bpa_datapath.sv -----
// Datapath of the block pool allocator: link memories, pool registers, result register.
`default_nettype none

module bpa_datapath import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bpa_cmd_t          cmd,
  output bpa_stat_t         stat,
  input  logic              req_type,
  input  logic [IDX_W-1:0]  slot_index,
  input  logic [TAG_W-1:0]  tag,
  input  logic [LEN_W-1:0]  length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [IDX_W-1:0]  granted_slot,
  output logic [TAG_W-1:0]  granted_tag,
  output logic [LEN_W-1:0]  granted_length,
  output logic              evicted,
  output logic [TAG_W-1:0]  evicted_tag,
  output logic              read_from_swap,
  output logic [CNT_W-1:0]  swapped_count,
  output logic [FREE_W-1:0] free_slots
);

  // Latched request.
  logic             req_free;
  logic [TAG_W-1:0] req_tag;
  logic [LEN_W-1:0] req_len;

  // Slot under work and pool bookkeeping.
  logic [ADDR_W-1:0] cur;
  logic [LINK_W-1:0] free_top;
  logic [LINK_W-1:0] oldest;
  logic [LINK_W-1:0] newest;
  logic [LINK_W-1:0] free_total;
  logic [LINK_W-1:0] fresh;
  logic [TAG_W-1:0]  tag_counter;
  logic [CNT_W-1:0]  swap_total;

  // Result being built.
  logic             res_status;
  logic [IDX_W-1:0] res_slot;
  logic [TAG_W-1:0] res_tag;
  logic             res_ev;
  logic [TAG_W-1:0] res_evtag;
  logic             res_rd;

  // Memory ports.
  logic [ADDR_W-1:0] rd_addr;
  logic              fwd_we, bwd_we, tm_we;
  logic [ADDR_W-1:0] fwd_wa, bwd_wa, tm_wa;
  logic [LINK_W-1:0] fwd_wd, bwd_wd;
  logic [TAG_W:0]    tm_wd;
  logic [LINK_W-1:0] fwd_rd, bwd_rd;
  logic [TAG_W:0]    tm_rd;

  // Derived values.
  logic              evict_need;
  logic              fresh_hit;
  logic [LINK_W-1:0] fwd_val;
  logic              live_val;
  logic [LINK_W-1:0] prev_link;
  logic [LINK_W-1:0] next_link;
  logic              prev_ok;
  logic              next_ok;
  logic              newest_ok;

  assign evict_need = (free_total == '0) && (oldest < NUM_LINK);

  // Slots at or above the fresh mark were never handed out: their forward
  // link is still the initial successor and they are not live.
  assign fresh_hit = LINK_W'(cur) >= fresh;
  assign fwd_val   = fresh_hit ? (LINK_W'(cur) + LINK_W'(1)) : fwd_rd;
  assign live_val  = !fresh_hit && tm_rd[TAG_W];
  assign prev_link = bwd_rd;
  assign next_link = fwd_val;
  assign prev_ok   = prev_link < NUM_LINK;
  assign next_ok   = next_link < NUM_LINK;
  assign newest_ok = newest < NUM_LINK;

  // Read address: the request picks the slot on a transfer, else the free top.
  always_comb begin
    if (cmd.rd_src == RD_TOP) begin
      rd_addr = free_top[ADDR_W-1:0];
    end else if (req_type == REQ_FREE) begin
      rd_addr = ADDR_W'(slot_index);
    end else if (evict_need) begin
      rd_addr = oldest[ADDR_W-1:0];
    end else begin
      rd_addr = free_top[ADDR_W-1:0];
    end
  end

  // Status to the controller.
  always_comb begin
    stat.in_free      = (req_type == REQ_FREE);
    stat.in_range_bad = LINK_W'(slot_index) >= NUM_LINK;
    stat.evict_need   = evict_need;
    stat.req_free     = req_free;
    stat.hit          = live_val && (tm_rd[TAG_W-1:0] == req_tag);
    stat.out_free     = !out_valid || out_ready;
  end

  // Memory writes for each step of unlink, push, pop and append.
  always_comb begin
    fwd_we = 1'b0;
    fwd_wa = cur;
    fwd_wd = NO_SLOT;
    bwd_we = 1'b0;
    bwd_wa = cur;
    bwd_wd = NO_SLOT;
    tm_we  = 1'b0;
    tm_wa  = cur;
    tm_wd  = '0;
    if (cmd.rel_link) begin
      fwd_we = prev_ok;
      fwd_wa = prev_link[ADDR_W-1:0];
      fwd_wd = next_link;
      bwd_we = next_ok;
      bwd_wa = next_link[ADDR_W-1:0];
      bwd_wd = prev_link;
      tm_we  = 1'b1;
    end
    if (cmd.rel_push) begin
      fwd_we = 1'b1;
      fwd_wd = free_top;
      bwd_we = 1'b1;
    end
    if (cmd.take_pop) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
      bwd_wd = newest;
      tm_we  = 1'b1;
      tm_wd  = {1'b1, tag_counter};
    end
    if (cmd.take_link) begin
      fwd_we = newest_ok;
      fwd_wa = newest[ADDR_W-1:0];
      fwd_wd = LINK_W'(cur);
    end
  end

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_fwd_ram (
    .clk     (clk),
    .wr_en   (fwd_we),
    .wr_addr (fwd_wa),
    .wr_data (fwd_wd),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_addr),
    .rd_data (fwd_rd)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BLOCKS)) u_bwd_ram (
    .clk     (clk),
    .wr_en   (bwd_we),
    .wr_addr (bwd_wa),
    .wr_data (bwd_wd),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_addr),
    .rd_data (bwd_rd)
  );

  bpa_ram #(.WIDTH(TAG_W + 1), .DEPTH(NUM_BLOCKS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (tm_we),
    .wr_addr (tm_wa),
    .wr_data (tm_wd),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_addr),
    .rd_data (tm_rd)
  );

  // Pool bookkeeping and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top    <= '0;
      oldest      <= NO_SLOT;
      newest      <= NO_SLOT;
      free_total  <= NUM_LINK;
      fresh       <= '0;
      tag_counter <= '0;
      swap_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.evict_mark && (swap_total != '1)) begin
        swap_total <= swap_total + CNT_W'(1);
      end
      if (cmd.stale && (swap_total != '0)) begin
        swap_total <= swap_total - CNT_W'(1);
      end
      if (cmd.rel_link) begin
        if (!prev_ok) begin
          oldest <= next_link;
        end
        if (!next_ok) begin
          newest <= prev_link;
        end
      end
      if (cmd.rel_push) begin
        free_top   <= LINK_W'(cur);
        free_total <= free_total + LINK_W'(1);
      end
      if (cmd.take_pop) begin
        free_top <= fwd_val;
        if (fresh_hit) begin
          fresh <= fresh + LINK_W'(1);
        end
      end
      if (cmd.take_link) begin
        if (!newest_ok) begin
          oldest <= LINK_W'(cur);
        end
        newest      <= LINK_W'(cur);
        free_total  <= free_total - LINK_W'(1);
        tag_counter <= tag_counter + TAG_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, working slot and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_free   <= (req_type == REQ_FREE);
      req_tag    <= tag;
      req_len    <= length;
      res_status <= ((req_type == REQ_FREE) && stat.in_range_bad) ? STATUS_RANGE : STATUS_OK;
      res_slot   <= slot_index;
      res_tag    <= tag;
      res_ev     <= 1'b0;
      res_evtag  <= '0;
      res_rd     <= 1'b0;
    end
    if (cmd.rd_issue) begin
      cur <= rd_addr;
    end
    if (cmd.evict_mark) begin
      res_ev    <= 1'b1;
      res_evtag <= tm_rd[TAG_W-1:0];
    end
    if (cmd.stale) begin
      res_rd <= 1'b1;
    end
    if (cmd.take_link) begin
      res_slot <= IDX_W'(cur);
      res_tag  <= tag_counter;
    end
    if (cmd.finish) begin
      status         <= res_status;
      granted_slot   <= res_slot;
      granted_tag    <= res_tag;
      granted_length <= req_len;
      evicted        <= res_ev;
      evicted_tag    <= res_evtag;
      read_from_swap <= res_rd;
      swapped_count  <= swap_total;
      free_slots     <= FREE_W'(free_total);
    end
  end

endmodule

`default_nettype wire

// ----- sv/bpa_ctrl.sv -----
// Controller state machine of the block pool allocator.
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  bpa_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        // No transfer is taken while reset is applied.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept   = 1'b1;
          cmd.rd_issue = 1'b1;
          cmd.rd_src   = RD_REQ;
          if (stat.in_free) begin
            state_next = stat.in_range_bad ? S_FIN : S_CHECK;
          end else begin
            state_next = stat.evict_need ? S_CHECK : S_TAKE2;
          end
        end
      end
      S_CHECK: begin
        if (stat.req_free) begin
          if (stat.hit) begin
            state_next = S_REL1;
          end else begin
            cmd.stale  = 1'b1;
            state_next = S_FIN;
          end
        end else begin
          cmd.evict_mark = 1'b1;
          state_next     = S_REL1;
        end
      end
      S_REL1: begin
        cmd.rel_link = 1'b1;
        state_next   = S_REL2;
      end
      S_REL2: begin
        cmd.rel_push = 1'b1;
        state_next   = stat.req_free ? S_FIN : S_TAKE1;
      end
      S_TAKE1: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_src   = RD_TOP;
        state_next   = S_TAKE2;
      end
      S_TAKE2: begin
        cmd.take_pop = 1'b1;
        state_next   = S_TAKE3;
      end
      S_TAKE3: begin
        cmd.take_link = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
